// ===== design/chr_pkg.sv =====
// chr_pkg: shared constants, types and hash helpers for the consistent hash ring.
// Used by chr_front, chr_queue, chr_back and consistent_hash_ring_top.
package chr_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  HASH_SEP  = 8'h23;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;

    localparam int RING_ENTRIES_DEF = 1024;
    localparam int NODE_IDS_DEF     = 64;
    localparam logic [6:0] VCOUNT_RESET = 7'd16;
    localparam int ENT_W   = 11;
    localparam int QDEPTH  = 2;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_VHASH,
        BS_SRCH,
        BS_SCMP,
        BS_LOOK,
        BS_CHK,
        BS_SHR,
        BS_SHW,
        BS_NEXT,
        BS_EMIT
    } t_bstate;

    typedef struct packed {
        t_req        req;
        logic [31:0] hash;
        logic [5:0]  ident;
    } t_job;

    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][3:0] d;   // d[0] is the first digit folded
    } t_digits;

    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {{24{b[7]}}, b};
        return x * FNV_PRIME;
    endfunction

    function automatic t_digits dec_digits(input logic [6:0] v);
        t_digits    r;
        logic       hu;
        logic [6:0] rem;
        logic [3:0] te;
        logic [3:0] on;
        hu  = (v >= 7'd100);
        rem = hu ? v - 7'd100 : v;
        te  = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(10 * k)) te = 4'(k);
        end
        on = 4'(rem - 7'(10 * te));
        if (hu) begin
            r.n = 2'd3;
            r.d = {on, te, 4'd1};
        end else if (te != 4'd0) begin
            r.n = 2'd2;
            r.d = {4'd0, on, te};
        end else begin
            r.n = 2'd1;
            r.d = {4'd0, 4'd0, on};
        end
        return r;
    endfunction

endpackage

// ===== design/consistent_hash_ring_top.sv =====
// consistent_hash_ring_top: FNV-1a keyed consistent hash ring, front, queue and back end.
// Depends on chr_pkg, chr_front, chr_queue and chr_back.
//
// Requests come in as name bytes, one per push while full is low; the byte
// with last set closes the name and carries the request kind and node number.
// Each closed name yields one result on the output queue: owner, status and
// the ring entry total. A result stays on the ports while empty is low and
// leaves on pop. Bytes are hashed one per cycle while full is low; a two-entry
// queue lets the front keep hashing the next name while the back end works on
// the ring. Lookup time is set by the binary search over the ring memory, which
// has one read and one write port. Add/remove: per virtual point a hash of the
// separator and digits, the same search, then a read and a write per moved entry.
// Reset empties the ring, restores the hash basis and sets the virtual count
// to 16; memory contents need no clearing. A stalled receiver holds the
// result register; the back end then waits and the queue fills until full.
module consistent_hash_ring_top #(
    parameter int RING_ENTRIES = chr_pkg::RING_ENTRIES_DEF,
    parameter int NODE_IDS     = chr_pkg::NODE_IDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [5:0]  i_node_ident,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_owner_node,
    output logic [1:0]  o_status,
    output logic [10:0] o_entry_total
);
    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;
    chr_pkg::t_job w_in_job, w_out_job;

    assign full = w_q_full;

    chr_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_req_type, .i_data_byte, .i_last,
        .i_node_ident, .i_q_full(w_q_full), .o_q_push(w_q_push), .o_q_job(w_in_job)
    );

    chr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_q_push), .i_job(w_in_job), .o_full(w_q_full),
        .i_pop(w_q_pop), .o_empty(w_q_empty), .o_job(w_out_job)
    );

    chr_back #(.RING_ENTRIES(RING_ENTRIES), .NODE_IDS(NODE_IDS)) u_back (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .i_q_empty(w_q_empty), .i_q_job(w_out_job), .o_q_pop(w_q_pop),
        .i_pop(pop), .o_empty(empty), .o_owner_node, .o_status, .o_entry_total
    );
endmodule

// ===== design/chr_queue.sv =====
// chr_queue: short request queue between the hashing front and the ring back end.
// Depends on chr_pkg (t_job, QDEPTH).
module chr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  chr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output chr_pkg::t_job o_job
);
    localparam int PW = $clog2(chr_pkg::QDEPTH);

    chr_pkg::t_job r_mem [chr_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(chr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(i_pop && !o_empty);
        end
    end
endmodule

// ===== design/chr_front.sv =====
// chr_front: folds name bytes into the running FNV-1a hash, one byte a cycle while the
// queue is not full, and queues a request on the final byte. Depends on chr_pkg.
module chr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic [5:0]    i_node_ident,
    input  logic          i_q_full,
    output logic          o_q_push,
    output chr_pkg::t_job o_q_job
);
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic        w_acc;

    assign w_acc    = i_push && !i_q_full;
    assign n_hash   = chr_pkg::fold_byte(r_hash, i_data_byte);
    assign o_q_push = w_acc && i_last;
    assign o_q_job  = '{req: chr_pkg::t_req'(i_req_type), hash: n_hash, ident: i_node_ident};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= chr_pkg::FNV_BASIS;
        end else if (w_acc) begin
            r_hash <= i_last ? chr_pkg::FNV_BASIS : n_hash;
        end
    end
endmodule

// ===== design/chr_back.sv =====
// chr_back: ring sequencer; binary search, insert and erase over the sorted ring memory.
// Depends on chr_pkg (states, requests, hash helpers).
module chr_back #(
    parameter int RING_ENTRIES = chr_pkg::RING_ENTRIES_DEF,
    parameter int NODE_IDS     = chr_pkg::NODE_IDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [6:0]    i_cfg_wr_data,
    input  logic          i_q_empty,
    input  chr_pkg::t_job i_q_job,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [5:0]    o_owner_node,
    output logic [1:0]    o_status,
    output logic [10:0]   o_entry_total
);
    localparam int AW = $clog2(RING_ENTRIES);
    localparam int CW = $clog2(RING_ENTRIES + 1);
    localparam int OW = (NODE_IDS > 1) ? $clog2(NODE_IDS) : 1;

    function automatic logic [OW-1:0] node_mod(input logic [5:0] id);
        logic [5:0] rem;
        rem = id;
        for (int k = 1; k < 64; k++) begin
            if (k * NODE_IDS <= 63 && int'(id) >= k * NODE_IDS) rem = id - 6'(k * NODE_IDS);
        end
        return OW'(rem);
    endfunction

    logic [31:0]   r_mem_hash [RING_ENTRIES];
    logic [OW-1:0] r_mem_own  [RING_ENTRIES];
    logic [31:0]   r_rd_hash;
    logic [OW-1:0] r_rd_own;

    chr_pkg::t_bstate r_st, n_st;
    chr_pkg::t_req    r_req, n_req;
    logic [31:0]      r_base, n_base, r_vh, n_vh;
    logic [OW-1:0]    r_own, n_own;
    logic [6:0]       r_vcnt, r_i, n_i;
    logic [1:0]       r_fs, n_fs;
    logic [CW-1:0]    r_count, n_count, r_lo, n_lo, r_hi, n_hi, r_j, n_j;
    logic [1:0]       r_stat, n_stat;
    logic [OW-1:0]    r_res_own, n_res_own;
    logic             r_out_valid, n_out_valid;
    logic [5:0]       r_out_own;
    logic [1:0]       r_out_stat;
    logic [10:0]      r_out_total;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_whash;
    logic [OW-1:0] w_wown;
    logic [CW-1:0] w_mid;
    logic          w_match;
    logic          w_load_out;
    chr_pkg::t_digits w_dig;

    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign w_match = (r_lo < r_count) && (r_rd_hash == r_vh);
    assign w_dig   = chr_pkg::dec_digits(r_i);

    always_comb begin
        n_st = r_st; n_req = r_req; n_base = r_base; n_vh = r_vh; n_own = r_own;
        n_i = r_i; n_fs = r_fs; n_count = r_count; n_lo = r_lo; n_hi = r_hi; n_j = r_j;
        n_stat = r_stat; n_res_own = r_res_own;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop = 1'b0; w_we = 1'b0; w_load_out = 1'b0;
        w_waddr = r_lo[AW-1:0]; w_raddr = r_lo[AW-1:0];
        w_whash = r_vh; w_wown = r_own;
        unique case (r_st)
            chr_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_req     = i_q_job.req;
                    n_base    = i_q_job.hash;
                    n_vh      = i_q_job.hash;
                    n_own     = node_mod(i_q_job.ident);
                    n_stat    = chr_pkg::ST_OK;
                    n_res_own = '0;
                    n_i = '0; n_fs = '0; n_lo = '0; n_hi = r_count;
                    unique case (i_q_job.req)
                        chr_pkg::REQ_LOOKUP: begin
                            if (r_count == '0) begin
                                n_stat = chr_pkg::ST_EMPTY;
                                n_st   = chr_pkg::BS_EMIT;
                            end else n_st = chr_pkg::BS_SRCH;
                        end
                        chr_pkg::REQ_ADD, chr_pkg::REQ_REMOVE:
                            n_st = (r_vcnt == '0) ? chr_pkg::BS_EMIT : chr_pkg::BS_VHASH;
                        default: n_st = chr_pkg::BS_EMIT;
                    endcase
                end
            end
            chr_pkg::BS_VHASH: begin
                if (r_fs == '0) n_vh = chr_pkg::fold_byte(r_base, chr_pkg::HASH_SEP);
                else n_vh = chr_pkg::fold_byte(r_vh, chr_pkg::CHAR_ZERO | {4'd0, w_dig.d[r_fs - 2'd1]});
                n_fs = r_fs + 2'd1;
                if (r_fs == w_dig.n) begin
                    n_lo = '0; n_hi = r_count;
                    n_st = chr_pkg::BS_SRCH;
                end
            end
            chr_pkg::BS_SRCH: begin
                if (r_lo < r_hi) begin
                    w_raddr = w_mid[AW-1:0];
                    n_st    = chr_pkg::BS_SCMP;
                end else if (r_req == chr_pkg::REQ_LOOKUP) begin
                    w_raddr = (r_lo >= r_count) ? '0 : r_lo[AW-1:0];
                    n_st    = chr_pkg::BS_LOOK;
                end else begin
                    w_raddr = r_lo[AW-1:0];
                    n_st    = chr_pkg::BS_CHK;
                end
            end
            chr_pkg::BS_SCMP: begin
                if (r_rd_hash < r_vh) n_lo = w_mid + 1'b1;
                else n_hi = w_mid;
                n_st = chr_pkg::BS_SRCH;
            end
            chr_pkg::BS_LOOK: begin
                n_res_own = r_rd_own;
                n_st      = chr_pkg::BS_EMIT;
            end
            chr_pkg::BS_CHK: begin
                if (r_req == chr_pkg::REQ_ADD) begin
                    if (w_match) begin
                        w_we = 1'b1;
                        n_st = chr_pkg::BS_NEXT;
                    end else if (r_count >= CW'(RING_ENTRIES)) begin
                        n_stat = chr_pkg::ST_FULL;
                        n_st   = chr_pkg::BS_NEXT;
                    end else begin
                        n_j  = r_count;
                        n_st = chr_pkg::BS_SHR;
                    end
                end else begin
                    n_j  = r_lo;
                    n_st = w_match ? chr_pkg::BS_SHR : chr_pkg::BS_NEXT;
                end
            end
            chr_pkg::BS_SHR: begin
                if (r_req == chr_pkg::REQ_ADD) begin
                    if (r_j > r_lo) begin
                        w_raddr = AW'(r_j - 1'b1);
                        n_st    = chr_pkg::BS_SHW;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_st    = chr_pkg::BS_NEXT;
                    end
                end else begin
                    if (r_j + 1'b1 < r_count) begin
                        w_raddr = AW'(r_j + 1'b1);
                        n_st    = chr_pkg::BS_SHW;
                    end else begin
                        n_count = r_count - 1'b1;
                        n_st    = chr_pkg::BS_NEXT;
                    end
                end
            end
            chr_pkg::BS_SHW: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_whash = r_rd_hash;
                w_wown  = r_rd_own;
                n_j     = (r_req == chr_pkg::REQ_ADD) ? r_j - 1'b1 : r_j + 1'b1;
                n_st    = chr_pkg::BS_SHR;
            end
            chr_pkg::BS_NEXT: begin
                if ({1'b0, r_i} + 8'd1 < {1'b0, r_vcnt}) begin
                    n_i  = r_i + 1'b1;
                    n_fs = '0;
                    n_st = chr_pkg::BS_VHASH;
                end else n_st = chr_pkg::BS_EMIT;
            end
            chr_pkg::BS_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_st        = chr_pkg::BS_IDLE;
                end
            end
            default: n_st = chr_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_hash[w_waddr] <= w_whash;
            r_mem_own[w_waddr]  <= w_wown;
        end
        r_rd_hash <= r_mem_hash[w_raddr];
        r_rd_own  <= r_mem_own[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= chr_pkg::BS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_vcnt      <= chr_pkg::VCOUNT_RESET;
        end else begin
            r_st        <= n_st;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_vcnt <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_base <= n_base; r_vh <= n_vh; r_own <= n_own;
        r_i <= n_i; r_fs <= n_fs; r_lo <= n_lo; r_hi <= n_hi; r_j <= n_j;
        r_stat <= n_stat; r_res_own <= n_res_own;
        if (w_load_out) begin
            r_out_own   <= 6'(r_res_own);
            r_out_stat  <= r_stat;
            r_out_total <= chr_pkg::ENT_W'(r_count);
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_owner_node  = r_out_own;
    assign o_status      = r_out_stat;
    assign o_entry_total = r_out_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_ENTRIES)) else $error("ring count overflow");
    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_stat == chr_pkg::ST_FULL) |-> r_req == chr_pkg::REQ_ADD)
        else $error("full status outside add");
    a_empty_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_stat == chr_pkg::ST_EMPTY) |-> r_res_own == '0)
        else $error("owner on empty ring");
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == chr_pkg::BS_IDLE) |=> (r_count == $past(r_count)))
        else $error("count moved while idle");
endmodule

// ===== tb/sv/consistent_hash_ring_top_tb.sv =====
// consistent_hash_ring_top_tb: self-checking testbench for the FNV-1a consistent hash ring.
// Depends on chr_pkg and consistent_hash_ring_top; a scoreboard class predicts every result.
module consistent_hash_ring_top_tb;

    localparam int RING_MAX  = 1024;
    localparam int LIMIT     = 20000000;
    localparam int N_RANDOM  = 1650;

    typedef struct packed {
        logic [5:0]  owner;
        logic [1:0]  status;
        logic [10:0] total;
    } t_ring_res;

    class ring_scoreboard;
        logic [31:0] name_hash;
        logic [31:0] pt_hash[RING_MAX];
        logic [5:0]  pt_owner[RING_MAX];
        int          n_points;
        logic [6:0]  points_per_node;
        t_ring_res   pending_q[$];
        int          mismatches;

        function new();
            name_hash       = chr_pkg::FNV_BASIS;
            n_points        = 0;
            points_per_node = chr_pkg::VCOUNT_RESET;
            mismatches      = 0;
        endfunction

        function logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
            logic [31:0] ext;
            ext = 32'($signed(b));
            return (h ^ ext) * chr_pkg::FNV_PRIME;
        endfunction

        function logic [31:0] point_hash(input logic [31:0] base, input int idx);
            logic [31:0] h;
            logic [7:0]  dig[4];
            int          nd;
            int          v;
            h  = mix(base, "#");
            nd = 0;
            v  = idx;
            do begin
                dig[nd] = 8'("0" + v % 10);
                nd++;
                v = v / 10;
            end while (v != 0 && nd < 4);
            for (int k = nd - 1; k >= 0; k--) h = mix(h, dig[k]);
            return h;
        endfunction

        function int first_at_least(input logic [31:0] key);
            int lo, hi, mid;
            lo = 0;
            hi = n_points;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (pt_hash[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            return lo;
        endfunction

        function bit place_point(input logic [31:0] key, input logic [5:0] who);
            int p;
            p = first_at_least(key);
            if (p < n_points && pt_hash[p] == key) begin
                pt_owner[p] = who;
                return 1;
            end
            if (n_points >= RING_MAX) return 0;
            for (int k = n_points; k > p; k--) begin
                pt_hash[k]  = pt_hash[k-1];
                pt_owner[k] = pt_owner[k-1];
            end
            pt_hash[p]  = key;
            pt_owner[p] = who;
            n_points++;
            return 1;
        endfunction

        function void drop_point(input logic [31:0] key);
            int p;
            p = first_at_least(key);
            if (p < n_points && pt_hash[p] == key) begin
                for (int k = p; k < n_points - 1; k++) begin
                    pt_hash[k]  = pt_hash[k+1];
                    pt_owner[k] = pt_owner[k+1];
                end
                n_points--;
            end
        endfunction

        function void note_request(input chr_pkg::t_req req, input logic [7:0] b,
                                   input logic lst, input logic [5:0] ident);
            t_ring_res   r;
            logic [31:0] h;
            int          p;
            name_hash = mix(name_hash, b);
            if (!lst) return;
            h         = name_hash;
            name_hash = chr_pkg::FNV_BASIS;
            r.owner   = '0;
            r.status  = chr_pkg::ST_OK;
            case (req)
                chr_pkg::REQ_LOOKUP: begin
                    if (n_points == 0) begin
                        r.status = chr_pkg::ST_EMPTY;
                    end else begin
                        p = first_at_least(h);
                        if (p >= n_points) p = 0;
                        r.owner = pt_owner[p];
                    end
                end
                chr_pkg::REQ_ADD: begin
                    for (int i = 0; i < points_per_node; i++)
                        if (!place_point(point_hash(h, i), ident)) r.status = chr_pkg::ST_FULL;
                end
                chr_pkg::REQ_REMOVE: begin
                    for (int i = 0; i < points_per_node; i++) drop_point(point_hash(h, i));
                end
                default: ;
            endcase
            r.total = 11'(n_points);
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void check_result(input t_ring_res got);
            t_ring_res want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result owner=%0d status=%0d total=%0d",
                             got.owner, got.status, got.total);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp owner=%0d status=%0d total=%0d, got %0d %0d %0d",
                             want.owner, want.status, want.total,
                             got.owner, got.status, got.total);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [6:0]  i_cfg_wr_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last = 1'b0;
    logic [5:0]  i_node_ident = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [5:0]  o_owner_node;
    logic [1:0]  o_status;
    logic [10:0] o_entry_total;

    consistent_hash_ring_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_node_ident  (i_node_ident),
        .empty         (empty),
        .pop           (pop),
        .o_owner_node  (o_owner_node),
        .o_status      (o_status),
        .o_entry_total (o_entry_total)
    );

    always #4 i_clk = ~i_clk;

    ring_scoreboard sb = new();
    int  hold_left  = 0;
    bit  no_gaps    = 0;
    int  n_bytes    = 0;
    int  cycles     = 0;
    logic [7:0] pool_b[16][4];
    int         pool_len[16];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("consistent_hash_ring_top verification failed");
            $finish;
        end
    end

    // result side: random stalls plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result({o_owner_node, o_status, o_entry_total});
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!no_gaps && $urandom_range(0, 9) < 3) stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input chr_pkg::t_req req, input logic [7:0] b, input logic lst,
                             input logic [5:0] ident);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_req_type   <= req;
        i_data_byte  <= b;
        i_last       <= lst;
        i_node_ident <= ident;
        do @(posedge i_clk); while (full);
        sb.note_request(req, b, lst, ident);
        n_bytes++;
    endtask

    task automatic send_name(input chr_pkg::t_req req, input logic [7:0] nm[$],
                             input logic [5:0] ident);
        for (int k = 0; k < nm.size(); k++) begin
            if (k == nm.size() - 1) send_byte(req, nm[k], 1'b1, ident);
            else send_byte(chr_pkg::t_req'($urandom_range(0, 3)), nm[k], 1'b0, 6'($urandom));
        end
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_points(input logic [6:0] v);
        wait_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.points_per_node = v;
    endtask

    task automatic send_pool(input chr_pkg::t_req req, input int idx, input logic [5:0] ident);
        logic [7:0] nm[$];
        for (int k = 0; k < pool_len[idx]; k++) nm.insert(nm.size(), pool_b[idx][k]);
        send_name(req, nm, ident);
    endtask

    task automatic send_random(input chr_pkg::t_req req, input int len);
        logic [7:0] nm[$];
        for (int k = 0; k < len; k++) nm.insert(nm.size(), 8'($urandom));
        send_name(req, nm, 6'($urandom));
    endtask

    initial begin
        int r;
        for (int p = 0; p < 16; p++) begin
            pool_len[p] = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++) pool_b[p][k] = 8'($urandom);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_name(chr_pkg::REQ_LOOKUP, '{8'h00}, 6'd0);
        send_name(chr_pkg::REQ_NONE, '{8'hFF}, 6'd63);
        send_name(chr_pkg::REQ_ADD, '{8'h61}, 6'd63);
        send_name(chr_pkg::REQ_LOOKUP, '{8'h00}, 6'd0);
        send_name(chr_pkg::REQ_LOOKUP, '{8'hFF, 8'h80, 8'h7F}, 6'd0);
        send_name(chr_pkg::REQ_ADD, '{8'h61}, 6'd5);
        send_name(chr_pkg::REQ_LOOKUP, '{8'h01}, 6'd0);
        send_name(chr_pkg::REQ_ADD, '{8'hFF, 8'h00}, 6'd0);
        send_name(chr_pkg::REQ_REMOVE, '{8'h61}, 6'd17);
        send_name(chr_pkg::REQ_REMOVE, '{8'h61}, 6'd17);
        send_name(chr_pkg::REQ_LOOKUP, '{8'h62}, 6'd0);
        set_points(7'd127);
        send_name(chr_pkg::REQ_ADD, '{8'h6E, 8'h31}, 6'd42);
        send_name(chr_pkg::REQ_LOOKUP, '{8'h6B}, 6'd0);
        send_name(chr_pkg::REQ_REMOVE, '{8'h6E, 8'h31}, 6'd0);
        set_points(7'd0);
        send_name(chr_pkg::REQ_ADD, '{8'h7A}, 6'd1);
        send_name(chr_pkg::REQ_REMOVE, '{8'hFF, 8'h00}, 6'd0);
        send_name(chr_pkg::REQ_NONE, '{8'h55}, 6'd0);
        set_points(7'd1);
        send_name(chr_pkg::REQ_REMOVE, '{8'hFF, 8'h00}, 6'd0);
        send_name(chr_pkg::REQ_LOOKUP, '{8'h00}, 6'd0);

        // random part: phases of different point counts
        n_bytes = 0;
        for (int ph = 0; n_bytes < N_RANDOM; ph++) begin
            case (ph % 6)
                0: set_points(7'($urandom_range(1, 8)));
                1: set_points(7'd64);
                2: set_points(7'($urandom_range(2, 12)));
                3: set_points(7'd0);
                4: set_points(7'($urandom_range(65, 127)));
                default: set_points(7'($urandom_range(1, 4)));
            endcase
            no_gaps = (ph % 4 == 2);
            if (ph == 2) hold_left = 400;
            for (int n = 0; n < ((ph % 6 == 1 || ph % 6 == 4) ? 6 : 40); n++) begin
                r = $urandom_range(0, 99);
                if (r < 50) send_random(chr_pkg::REQ_LOOKUP, $urandom_range(1, 6));
                else if (r < 70)
                    send_pool(chr_pkg::REQ_ADD, $urandom_range(0, 15), 6'($urandom));
                else if (r < 92)
                    send_pool(chr_pkg::REQ_REMOVE, $urandom_range(0, 15), 6'($urandom));
                else if (r < 96) send_random(chr_pkg::REQ_NONE, $urandom_range(1, 3));
                else send_random(chr_pkg::t_req'($urandom_range(1, 2)), $urandom_range(1, 5));
            end
            // remove all pool names at 127 points so later phases stay short
            set_points(7'd127);
            for (int p = 0; p < 16; p++) send_pool(chr_pkg::REQ_REMOVE, p, 6'd0);
            no_gaps = 0;
        end

        // fill the ring until points are dropped
        set_points(7'd127);
        for (int n = 0; n < 10; n++) begin
            send_name(chr_pkg::REQ_ADD, '{8'hA0, 8'(n), 8'h5A}, 6'($urandom));
            send_random(chr_pkg::REQ_LOOKUP, 3);
        end
        send_name(chr_pkg::REQ_ADD, '{8'hA0, 8'd0, 8'h5A}, 6'd9);
        for (int n = 0; n < 20; n++) send_random(chr_pkg::REQ_LOOKUP, $urandom_range(1, 4));

        wait_drain();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("consistent_hash_ring_top verification clean");
        end else begin
            $display("consistent_hash_ring_top verification failed");
        end
        $finish;
    end

endmodule
